@@ hdl/zrci_pkg.sv @@
// Shared types, constants and the injected program table for the register capture injector.
// Depends on nothing; used by zrci_core and z80_register_capture_injector.
`default_nettype none

package zrci_pkg;

    // Program length and the positions of the patched bytes.
    localparam int unsigned PROG_LEN    = 36;
    localparam logic [5:0]  POS_R_PATCH = 6'd28;
    localparam logic [5:0]  POS_F_PATCH = 6'd32;
    localparam logic [5:0]  POS_A_PATCH = 6'd33;
    localparam logic [5:0]  POS_LAST    = 6'(PROG_LEN - 1);
    localparam logic [7:0]  R_ADJUST    = 8'd3;
    localparam logic [7:0]  R_PATCH_ADJ = 8'd2;
    localparam logic [15:0] HIGH_MASK   = 16'hff00;

    // Register identifiers as reported on the update fields.
    localparam logic [3:0] ID_AF  = 4'd0;
    localparam logic [3:0] ID_BC  = 4'd1;
    localparam logic [3:0] ID_DE  = 4'd2;
    localparam logic [3:0] ID_HL  = 4'd3;
    localparam logic [3:0] ID_AF2 = 4'd4;
    localparam logic [3:0] ID_BC2 = 4'd5;
    localparam logic [3:0] ID_DE2 = 4'd6;
    localparam logic [3:0] ID_HL2 = 4'd7;
    localparam logic [3:0] ID_IX  = 4'd8;
    localparam logic [3:0] ID_IY  = 4'd9;
    localparam logic [3:0] ID_SP  = 4'd10;
    localparam logic [3:0] ID_I   = 4'd11;
    localparam logic [3:0] ID_R   = 4'd12;

    // Program steps at which a write carries register contents.
    localparam logic [5:0] STEP_AF   = 6'd1;
    localparam logic [5:0] STEP_HL_R = 6'd4;
    localparam logic [5:0] STEP_I    = 6'd7;
    localparam logic [5:0] STEP_DE   = 6'd10;
    localparam logic [5:0] STEP_BC   = 6'd11;
    localparam logic [5:0] STEP_HL2  = 6'd13;
    localparam logic [5:0] STEP_DE2  = 6'd14;
    localparam logic [5:0] STEP_BC2  = 6'd15;
    localparam logic [5:0] STEP_AF2  = 6'd18;
    localparam logic [5:0] STEP_IX   = 6'd23;
    localparam logic [5:0] STEP_IY   = 6'd27;

    // One bus word as it enters the block.
    typedef struct packed {
        logic        req_type;
        logic [15:0] bus_addr;
        logic [7:0]  bus_data;
        logic        is_write;
    } req_t;

    // One result word.
    typedef struct packed {
        logic        drive_valid;
        logic [7:0]  drive_byte;
        logic        first_valid;
        logic [3:0]  first_reg;
        logic [15:0] first_value;
        logic        second_valid;
        logic [3:0]  second_reg;
        logic [15:0] second_value;
        logic        sequence_done;
    } result_t;

    // Fixed program that makes the processor push out its registers.
    function automatic logic [7:0] prog_byte(input logic [5:0] idx);
        logic [7:0] b;
        unique case (idx)
            6'd0:  b = 8'hF5;  6'd1:  b = 8'hED;  6'd2:  b = 8'h5F;  6'd3:  b = 8'h77;
            6'd4:  b = 8'hED;  6'd5:  b = 8'h57;  6'd6:  b = 8'h77;  6'd7:  b = 8'h33;
            6'd8:  b = 8'h33;  6'd9:  b = 8'h12;  6'd10: b = 8'h02;  6'd11: b = 8'hD9;
            6'd12: b = 8'h77;  6'd13: b = 8'h12;  6'd14: b = 8'h02;  6'd15: b = 8'hD9;
            6'd16: b = 8'h08;  6'd17: b = 8'hF5;  6'd18: b = 8'h33;  6'd19: b = 8'h33;
            6'd20: b = 8'h08;  6'd21: b = 8'hDD;  6'd22: b = 8'hE5;  6'd23: b = 8'h33;
            6'd24: b = 8'h33;  6'd25: b = 8'hFD;  6'd26: b = 8'hE5;  6'd27: b = 8'h3E;
            6'd28: b = 8'h00;  6'd29: b = 8'hED;  6'd30: b = 8'h4F;  6'd31: b = 8'hF1;
            6'd32: b = 8'h00;  6'd33: b = 8'h00;  6'd34: b = 8'h18;  6'd35: b = 8'hDE;
            default: b = 8'hDE;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

@@ hdl/zrci_core.sv @@
// Sequence state, patch bytes and captured register halves, with the per-word decode.
// Depends on zrci_pkg; instantiated by z80_register_capture_injector.
`default_nettype none

module zrci_core
    import zrci_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    go,
    input  wire req_t    req,
    output      result_t res
);

    logic [5:0]  step_reg, step_next;
    logic        seen_reg, seen_next;
    logic        active_reg, active_next;
    logic [7:0]  r_patch_reg, r_patch_next;
    logic [7:0]  f_patch_reg, f_patch_next;
    logic [7:0]  a_patch_reg, a_patch_next;
    // Only the registers whose old value feeds a later update are kept.
    logic [15:0] af_reg, af_next;
    logic [15:0] af2_reg, af2_next;
    logic [15:0] ix_reg, ix_next;
    logic [15:0] iy_reg, iy_next;
    logic [5:0]  rd_pos;
    logic [7:0]  r_val;
    logic [15:0] pair_old;
    logic [15:0] pair_new;

    // Clamped read position and the shared value paths.
    assign rd_pos = (step_reg > POS_LAST) ? POS_LAST : step_reg;
    assign r_val  = req.bus_data - R_ADJUST;

    always_comb
    begin
        unique case (step_reg)
            STEP_AF2: pair_old = af2_reg;
            STEP_IX:  pair_old = ix_reg;
            default:  pair_old = iy_reg;
        endcase
        if (!seen_reg)
            pair_new = {req.bus_data, pair_old[7:0]};
        else
            pair_new = (pair_old & HIGH_MASK) | {8'h00, req.bus_data};
    end

    // Decode of one word and the next state.
    always_comb
    begin
        res          = '0;
        step_next    = step_reg;
        seen_next    = seen_reg;
        active_next  = active_reg;
        r_patch_next = r_patch_reg;
        f_patch_next = f_patch_reg;
        a_patch_next = a_patch_reg;
        af_next      = af_reg;
        af2_next     = af2_reg;
        ix_next      = ix_reg;
        iy_next      = iy_reg;

        if (req.req_type)
        begin
            step_next   = '0;
            seen_next   = 1'b0;
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            res.drive_valid = 1'b1;
            if (req.is_write)
            begin
                unique case (step_reg)
                    STEP_AF:
                    begin
                        res.first_valid = 1'b1;
                        res.first_reg   = ID_AF;
                        if (!seen_reg)
                        begin
                            seen_next        = 1'b1;
                            a_patch_next     = req.bus_data;
                            res.first_value  = {req.bus_data, 8'h00};
                            res.second_valid = 1'b1;
                            res.second_reg   = ID_SP;
                            res.second_value = req.bus_addr + 16'd1;
                        end
                        else
                        begin
                            f_patch_next    = req.bus_data;
                            res.first_value = (af_reg & HIGH_MASK) | {8'h00, req.bus_data};
                        end
                        af_next = res.first_value;
                    end
                    STEP_HL_R:
                    begin
                        res.first_valid  = 1'b1;
                        res.first_reg    = ID_HL;
                        res.first_value  = req.bus_addr;
                        res.second_valid = 1'b1;
                        res.second_reg   = ID_R;
                        res.second_value = {8'h00, r_val};
                        r_patch_next     = r_val - R_PATCH_ADJ;
                    end
                    STEP_I:
                    begin
                        res.first_valid = 1'b1;
                        res.first_reg   = ID_I;
                        res.first_value = {8'h00, req.bus_data};
                    end
                    STEP_DE, STEP_BC, STEP_HL2, STEP_DE2, STEP_BC2:
                    begin
                        res.first_valid = 1'b1;
                        res.first_value = req.bus_addr;
                        unique case (step_reg)
                            STEP_DE:  res.first_reg = ID_DE;
                            STEP_BC:  res.first_reg = ID_BC;
                            STEP_HL2: res.first_reg = ID_HL2;
                            STEP_DE2: res.first_reg = ID_DE2;
                            default:  res.first_reg = ID_BC2;
                        endcase
                    end
                    STEP_AF2, STEP_IX, STEP_IY:
                    begin
                        seen_next       = 1'b1;
                        res.first_valid = 1'b1;
                        res.first_value = pair_new;
                        unique case (step_reg)
                            STEP_AF2:
                            begin
                                res.first_reg = ID_AF2;
                                af2_next      = pair_new;
                            end
                            STEP_IX:
                            begin
                                res.first_reg = ID_IX;
                                ix_next       = pair_new;
                            end
                            default:
                            begin
                                res.first_reg = ID_IY;
                                iy_next       = pair_new;
                            end
                        endcase
                    end
                    default:
                    begin
                        // Absorbed with nothing to capture.
                    end
                endcase
            end
            else
            begin
                priority if (rd_pos == POS_R_PATCH)
                    res.drive_byte = r_patch_reg;
                else if (rd_pos == POS_F_PATCH)
                    res.drive_byte = f_patch_reg;
                else if (rd_pos == POS_A_PATCH)
                    res.drive_byte = a_patch_reg;
                else
                    res.drive_byte = prog_byte(rd_pos);
                step_next = rd_pos + 6'd1;
                seen_next = 1'b0;
                if (rd_pos == POS_LAST)
                begin
                    active_next       = 1'b0;
                    res.sequence_done = 1'b1;
                end
            end
        end
    end

    // State registers move only when a word passes through.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= '0;
            seen_reg    <= 1'b0;
            active_reg  <= 1'b0;
            r_patch_reg <= '0;
            f_patch_reg <= '0;
            a_patch_reg <= '0;
            af_reg      <= '0;
            af2_reg     <= '0;
            ix_reg      <= '0;
            iy_reg      <= '0;
        end
        else if (go)
        begin
            step_reg    <= step_next;
            seen_reg    <= seen_next;
            active_reg  <= active_next;
            r_patch_reg <= r_patch_next;
            f_patch_reg <= f_patch_next;
            a_patch_reg <= a_patch_next;
            af_reg      <= af_next;
            af2_reg     <= af2_next;
            ix_reg      <= ix_next;
            iy_reg      <= iy_next;
        end
    end

    // An active sequence never runs past the last program byte.
    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (step_reg <= POS_LAST))
        else $error("program step past end while active");

    // A finished sequence leaves the block inactive.
    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        go && res.sequence_done |=> !active_reg)
        else $error("sequence still active after done");

    // Register updates only occur on taken write cycles.
    a_update_on_write: assert property (@(posedge clk) disable iff (!rst_n)
        res.first_valid |-> (res.drive_valid && req.is_write && active_reg))
        else $error("register update outside a taken write");

    // A second update never appears without a first.
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        res.second_valid |-> res.first_valid)
        else $error("second update without first");

endmodule

`default_nettype wire

@@ hdl/z80_register_capture_injector.sv @@
// Top level of the register capture injector: input register, output register, handshakes.
// Depends on zrci_pkg and zrci_core.
//
// Usage: every processor memory cycle, and every request to start a capture sequence,
// is sent in as one word on the input channel (in_valid / in_stall). Every word gives
// exactly one result word on the output channel (out_valid / out_stall), in order.
// A start request resets the sequence and answers with an all-zero result. While a
// sequence runs, reads are answered with the next injected program byte on drive_byte
// and writes are absorbed, reporting up to two captured register values.
// Path: an accepted word is held in the input register, then in the result register,
// from which it is shown on the outputs.
// Throughput: one word per clock while no result is held back by out_stall, set by the
// single pass of decode logic between the two registers.
// Stall: when out_stall holds a waiting result, the input register still takes one
// more word; in_stall rises only once both registers are full.
// Reset: rst_n clears both stage valids, the sequence state, patch bytes and the
// captured register values; no sequence is active until a start request arrives.
`default_nettype none

module z80_register_capture_injector
    import zrci_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output      logic        in_stall,
    input  wire logic        req_type,
    input  wire logic [15:0] bus_addr,
    input  wire logic [7:0]  bus_data,
    input  wire logic        is_write,
    output      logic        out_valid,
    input  wire logic        out_stall,
    output      logic        drive_valid,
    output      logic [7:0]  drive_byte,
    output      logic        first_valid,
    output      logic [3:0]  first_reg,
    output      logic [15:0] first_value,
    output      logic        second_valid,
    output      logic [3:0]  second_reg,
    output      logic [15:0] second_value,
    output      logic        sequence_done
);

    logic    in_vld_reg;
    req_t    in_word_reg;
    logic    out_vld_reg;
    result_t out_word_reg;
    result_t res;
    logic    out_free;
    logic    advance;

    // Stage control.
    assign out_free = !out_vld_reg || !out_stall;
    assign advance  = in_vld_reg && out_free;
    assign in_stall = in_vld_reg && !out_free;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (!in_stall)
            in_vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
            in_word_reg <= '{req_type: req_type, bus_addr: bus_addr,
                             bus_data: bus_data, is_write: is_write};
    end

    zrci_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (advance),
        .req   (in_word_reg),
        .res   (res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (out_free)
            out_vld_reg <= in_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_word_reg <= res;
    end

    assign out_valid     = out_vld_reg;
    assign drive_valid   = out_word_reg.drive_valid;
    assign drive_byte    = out_word_reg.drive_byte;
    assign first_valid   = out_word_reg.first_valid;
    assign first_reg     = out_word_reg.first_reg;
    assign first_value   = out_word_reg.first_value;
    assign second_valid  = out_word_reg.second_valid;
    assign second_reg    = out_word_reg.second_reg;
    assign second_value  = out_word_reg.second_value;
    assign sequence_done = out_word_reg.sequence_done;

    // The input side only stalls while a result is held back.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_vld_reg && out_stall && in_vld_reg))
        else $error("input stalled without a held result");

    // A word in the input register reaches the result register once it is free.
    a_advance: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_vld_reg)
        else $error("advanced word lost");

    // A shown end of sequence always belongs to a taken read.
    a_done_taken: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && out_word_reg.sequence_done |->
            (out_word_reg.drive_valid && !out_word_reg.first_valid))
        else $error("sequence end on a cycle not taken as a read");

endmodule

`default_nettype wire
